/* rtl/csvt_pkg.sv */
// csvt_pkg: shared types, codes and constants of the CSV field tokenizer.
// No dependencies; every other file of the block imports it.
`default_nettype none

package csvt_pkg;

	// widths of the fixed port fields
	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 2;
	localparam int COL_OUT_W = 16;
	localparam int ROW_OUT_W = 32;

	// defaults of the counter widths
	localparam int COLUMN_BITS_DEF = 16;
	localparam int ROW_BITS_DEF    = 32;

	// configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic [APB_ADDR_W-3:0] REG_DELIMITER = '0;
	localparam logic [BYTE_W-1:0] DELIMITER_RESET = 8'h2C;

	// special bytes
	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CONTENT     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FIELD_END   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ROW_END     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNTERMINATED = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [BYTE_W-1:0]    value;
		logic [COL_OUT_W-1:0] column_count;
		logic [ROW_OUT_W-1:0] row_number;
		logic [COL_OUT_W-1:0] max_columns;
	} csvt_res_t;

	// results of one input item: first, and second when two is set
	typedef struct packed {
		csvt_res_t first;
		csvt_res_t second;
		logic      two;
	} csvt_pair_t;

endpackage

`default_nettype wire

/* rtl/csvt_stream_if.sv */
// csvt_in_if / csvt_out_if: valid/ready channels of the tokenizer.
// Depend on csvt_pkg for field widths.
`default_nettype none

interface csvt_in_if import csvt_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface csvt_out_if import csvt_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [BYTE_W-1:0]    value;
	logic [COL_OUT_W-1:0] column_count;
	logic [ROW_OUT_W-1:0] row_number;
	logic [COL_OUT_W-1:0] max_columns;
	logic                 last;

	modport source (output valid, output kind, output value, output column_count,
		output row_number, output max_columns, output last, input ready);
	modport sink (input valid, input kind, input value, input column_count,
		input row_number, input max_columns, input last, output ready);
endinterface

`default_nettype wire

/* rtl/csvt_apb_regs.sv */
// csvt_apb_regs: APB-style configuration register (delimiter byte).
// Depends on csvt_pkg.
`default_nettype none

module csvt_apb_regs import csvt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [BYTE_W-1:0]     delimiter
);

	logic [BYTE_W-1:0] delimiter_q;
	logic              hit;

	assign pready    = 1'b1;
	assign hit       = (paddr[APB_ADDR_W-1:2] == REG_DELIMITER);
	assign delimiter = delimiter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= DELIMITER_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			delimiter_q <= pwdata[BYTE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata[BYTE_W-1:0] = delimiter_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/csvt_parser.sv */
// csvt_parser: input register, parse state and counters, and the per-byte
// step logic that forms up to two results. Depends on csvt_pkg, csvt_in_if.
`default_nettype none

module csvt_parser import csvt_pkg::*; #(
	parameter int COLUMN_BITS = COLUMN_BITS_DEF,
	parameter int ROW_BITS    = ROW_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] delimiter,
	csvt_in_if.sink           bytes,
	output csvt_pair_t        pair,
	output logic              push,
	input  logic              take_ok
);

	localparam logic [2:0] ST_ROW_START   = 3'd0;
	localparam logic [2:0] ST_FIELD_START = 3'd1;
	localparam logic [2:0] ST_PLAIN       = 3'd2;
	localparam logic [2:0] ST_QUOTED      = 3'd3;
	localparam logic [2:0] ST_QUOTE_SEEN  = 3'd4;

	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eoi_s1;

	logic [2:0]             st_q, st_n;
	logic                   crp_q, crp_n;
	logic [COLUMN_BITS-1:0] fields_q, fields_n, widest_q, widest_n;
	logic [ROW_BITS-1:0]    rows_q, rows_n;

	logic                   is_delim, is_lf, is_quote;
	logic                   do_content, do_end, do_err, crp_eff, row_on;
	logic                   pre_cr, main_v, any, advance;
	logic [BYTE_W-1:0]      cb;
	logic [COLUMN_BITS-1:0] f_inc, w_max;
	logic [ROW_BITS-1:0]    r_inc;
	csvt_res_t              base_res, cr_res, main_res;

	assign is_delim = (byte_s1 == delimiter);
	assign is_lf    = (byte_s1 == CH_LF);
	assign is_quote = (byte_s1 == CH_QUOTE);

	assign f_inc = (fields_q == '1) ? fields_q : fields_q + 1'b1;
	assign r_inc = (rows_q == '1) ? rows_q : rows_q + 1'b1;
	assign w_max = (f_inc > widest_q) ? f_inc : widest_q;

	// decode the byte against the parse state
	always_comb begin
		crp_eff    = crp_q;
		do_content = 1'b0;
		do_end     = 1'b0;
		do_err     = 1'b0;
		cb         = byte_s1;
		st_n       = st_q;
		if (eoi_s1) begin
			unique case (st_q)
				ST_FIELD_START, ST_PLAIN, ST_QUOTE_SEEN: do_end = 1'b1;
				ST_QUOTED: do_err = 1'b1;
				default: ;
			endcase
		end else begin
			unique case (st_q)
				ST_PLAIN: begin
					if (is_delim || is_lf) do_end = 1'b1;
					else do_content = 1'b1;
				end
				ST_QUOTED: begin
					if (is_quote) st_n = ST_QUOTE_SEEN;
					else do_content = 1'b1;
				end
				ST_QUOTE_SEEN: begin
					if (is_quote) begin
						do_content = 1'b1;
						cb         = CH_QUOTE;
						st_n       = ST_QUOTED;
					end else begin
						do_end = 1'b1;
					end
				end
				default: begin
					crp_eff = 1'b0;
					priority if (is_quote) begin
						st_n = ST_QUOTED;
					end else if (is_delim || is_lf) begin
						do_end = 1'b1;
					end else begin
						st_n       = ST_PLAIN;
						do_content = 1'b1;
					end
				end
			endcase
		end
	end

	assign row_on = !eoi_s1 && is_delim;
	// a held CR goes out late, except when LF ends the field
	assign pre_cr = crp_eff && (do_content || (do_end && (eoi_s1 || !is_lf)));
	assign main_v = (do_content && (cb != CH_CR)) || do_end || do_err;
	assign any    = pre_cr || main_v;

	always_comb begin
		base_res.kind         = KIND_CONTENT;
		base_res.value        = '0;
		base_res.column_count = COL_OUT_W'(fields_q);
		base_res.row_number   = ROW_OUT_W'(rows_q);
		base_res.max_columns  = COL_OUT_W'(widest_q);

		cr_res       = base_res;
		cr_res.value = CH_CR;

		main_res = base_res;
		if (do_end) begin
			main_res.kind         = row_on ? KIND_FIELD_END : KIND_ROW_END;
			main_res.column_count = COL_OUT_W'(f_inc);
			main_res.max_columns  = COL_OUT_W'(row_on ? widest_q : w_max);
		end else if (do_err) begin
			main_res.kind = KIND_UNTERMINATED;
		end else begin
			main_res.value = cb;
		end

		pair.first  = pre_cr ? cr_res : main_res;
		pair.second = main_res;
		pair.two    = pre_cr && main_v;
	end

	// next state
	always_comb begin
		crp_n    = crp_eff;
		fields_n = fields_q;
		rows_n   = rows_q;
		widest_n = widest_q;
		if (do_content) begin
			crp_n = (cb == CH_CR);
		end
		if (do_end) begin
			crp_n = 1'b0;
			if (row_on) begin
				fields_n = f_inc;
			end else begin
				fields_n = '0;
				rows_n   = r_inc;
				widest_n = w_max;
			end
		end
	end

	assign advance     = v_s1 && (!any || take_ok);
	assign push        = v_s1 && any && take_ok;
	assign bytes.ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (bytes.ready) begin
			v_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data_byte;
			eoi_s1  <= bytes.end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_ROW_START;
			crp_q    <= 1'b0;
			fields_q <= '0;
			rows_q   <= '0;
			widest_q <= '0;
		end else if (advance) begin
			if (eoi_s1) begin
				// end of document: back to reset values
				st_q     <= ST_ROW_START;
				crp_q    <= 1'b0;
				fields_q <= '0;
				rows_q   <= '0;
				widest_q <= '0;
			end else begin
				st_q     <= do_end ? (row_on ? ST_FIELD_START : ST_ROW_START) : st_n;
				crp_q    <= crp_n;
				fields_q <= fields_n;
				rows_q   <= rows_n;
				widest_q <= widest_n;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_cr_at_field_start: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROW_START || st_q == ST_FIELD_START) |-> !crp_q)
		else $error("held CR at the start of a field");

	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eoi_s1 |=> fields_q == '0 && rows_q == '0 && widest_q == '0
			&& st_q == ST_ROW_START)
		else $error("counts not cleared after end of input");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> take_ok && v_s1)
		else $error("results pushed into a full result register");
`endif

endmodule

`default_nettype wire

/* rtl/csvt_result_buf.sv */
// csvt_result_buf: result register holding the results of one item and
// sending them in order on the output channel. Depends on csvt_pkg, csvt_out_if.
`default_nettype none

module csvt_result_buf import csvt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  csvt_pair_t pair,
	input  logic       push,
	output logic       take_ok,
	csvt_out_if.source tokens
);

	logic       occ_q;
	logic       sel_q;
	csvt_pair_t pair_q;
	csvt_res_t  cur;
	logic       is_last;

	assign cur     = sel_q ? pair_q.second : pair_q.first;
	assign is_last = !(pair_q.two && !sel_q);
	// room when empty or when the final result goes out now
	assign take_ok = !occ_q || (tokens.ready && is_last);

	assign tokens.valid        = occ_q;
	assign tokens.kind         = cur.kind;
	assign tokens.value        = cur.value;
	assign tokens.column_count = cur.column_count;
	assign tokens.row_number   = cur.row_number;
	assign tokens.max_columns  = cur.max_columns;
	assign tokens.last         = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (push) begin
			occ_q <= 1'b1;
			sel_q <= 1'b0;
		end else if (occ_q && tokens.ready) begin
			if (is_last) begin
				occ_q <= 1'b0;
				sel_q <= 1'b0;
			end else begin
				sel_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pair_q <= pair;
		end
	end

`ifndef NO_ASSERTIONS
	a_second_only_with_pair: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q && sel_q |-> pair_q.two)
		else $error("second result shown for a single-result item");

	a_two_at_most: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q && sel_q && tokens.ready |=> !occ_q || !sel_q)
		else $error("more than two results for one item");

	a_push_into_room: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q && !tokens.ready |-> !push)
		else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

/* rtl/csv_field_tokenizer_top.sv */
// Channel   Dir  Payload
// bytes     in   data_byte[7:0], end_of_input
// tokens    out  kind[1:0], value[7:0], column_count[15:0], row_number[31:0],
//                max_columns[15:0], last
// apb       cfg  delimiter at byte address 0 (reset 0x2C)
//
// One byte per cycle while the output takes every result; an item that
// gives two results holds the result register until both have gone out.
// From input transfer to first result, a byte passes the input register,
// then the result register.
// arst_n clears parse state, counters and both valid flags; no clearing pass.
// A stalled output holds the result register; the input register keeps
// taking bytes that give no result and holds the first one that does, and
// bytes.ready drops while that byte waits.
// Top level of the CSV field tokenizer. Depends on csvt_pkg, the channel
// interfaces, csvt_apb_regs, csvt_parser and csvt_result_buf.
`default_nettype none

module csv_field_tokenizer_top import csvt_pkg::*; #(
	parameter int COLUMN_BITS = COLUMN_BITS_DEF,
	parameter int ROW_BITS    = ROW_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	csvt_in_if.sink               bytes,
	csvt_out_if.source            tokens
);

	logic [BYTE_W-1:0] delimiter;
	csvt_pair_t        pair;
	logic              push;
	logic              take_ok;

	csvt_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.delimiter (delimiter)
	);

	csvt_parser #(
		.COLUMN_BITS (COLUMN_BITS),
		.ROW_BITS    (ROW_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.delimiter (delimiter),
		.bytes     (bytes),
		.pair      (pair),
		.push      (push),
		.take_ok   (take_ok)
	);

	csvt_result_buf u_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.pair    (pair),
		.push    (push),
		.take_ok (take_ok),
		.tokens  (tokens)
	);

endmodule

`default_nettype wire

/* bench/testbench.sv */
// testbench: drives csv_field_tokenizer_top one byte per transfer and checks every token
// against a predictor of the tokenizer, with random idling on both channels.
// Depends on csvt_pkg, csvt_in_if/csvt_out_if and the RTL top level.
`default_nettype none

module testbench import csvt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		PS_ROW_START,
		PS_FIELD_START,
		PS_PLAIN,
		PS_QUOTED,
		PS_QUOTE_SEEN
	} parse_state_e;

	typedef struct packed {
		csvt_res_t res;
		logic      last;
	} token_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              eoi;
	} doc_item_t;

	// one row of the opening sequence; typed rows carry their token in line
	typedef struct packed {
		logic [BYTE_W-1:0]    data;
		logic                 eoi;
		logic                 typed;
		logic                 has_token;
		logic [KIND_W-1:0]    kind;
		logic [BYTE_W-1:0]    value;
		logic [COL_OUT_W-1:0] cols;
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] widest;
	} plan_row_t;

	localparam logic [APB_ADDR_W-1:0] DELIM_ADDR = {REG_DELIMITER, 2'b00};
	localparam int PHASE_ITEMS = 82;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	csvt_in_if  bytes_if ();
	csvt_out_if tokens_if ();

	csv_field_tokenizer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.bytes   (bytes_if),
		.tokens  (tokens_if)
	);

	always #5ns clk = ~clk;

	// tokenizer state as the testbench tracks it
	logic [BYTE_W-1:0]    delim_cfg;
	parse_state_e         pstate;
	logic                 cr_held;
	logic [COL_OUT_W-1:0] cols_now;
	logic [ROW_OUT_W-1:0] rows_now;
	logic [COL_OUT_W-1:0] widest_now;

	token_t    due_tokens[$];
	csvt_res_t step_tokens[$];
	doc_item_t doc_queue[$];
	int        fail_count = 0;
	int        send_calm = 0;

	plan_row_t opening_bytes [30] = '{
		'{8'h61, 1'b0, 1'b1, 1'b1, KIND_CONTENT, 8'h61, 16'd0, 32'd0, 16'd0},
		'{DELIMITER_RESET, 1'b0, 1'b1, 1'b1, KIND_FIELD_END, 8'h00, 16'd1, 32'd0, 16'd0},
		'{CH_LF, 1'b0, 1'b1, 1'b1, KIND_ROW_END, 8'h00, 16'd2, 32'd0, 16'd2},
		'{8'hA5, 1'b1, 1'b1, 1'b0, KIND_CONTENT, 8'h00, 16'd0, 32'd0, 16'd0},
		'{CH_QUOTE, 1'b0, 1'b1, 1'b0, KIND_CONTENT, 8'h00, 16'd0, 32'd0, 16'd0},
		'{CH_CR, 1'b0, 1'b1, 1'b0, KIND_CONTENT, 8'h00, 16'd0, 32'd0, 16'd0},
		'{8'h00, 1'b1, 1'b1, 1'b1, KIND_UNTERMINATED, 8'h00, 16'd0, 32'd0, 16'd0},
		'{8'hFF, 1'b0, 1'b1, 1'b1, KIND_CONTENT, 8'hFF, 16'd0, 32'd0, 16'd0},
		'{CH_CR, 1'b0, 1'b1, 1'b0, KIND_CONTENT, 8'h00, 16'd0, 32'd0, 16'd0},
		'{CH_LF, 1'b0, 1'b1, 1'b1, KIND_ROW_END, 8'h00, 16'd1, 32'd0, 16'd1},
		'{CH_LF, 1'b0, 1'b1, 1'b1, KIND_ROW_END, 8'h00, 16'd1, 32'd1, 16'd1},
		'{8'h00, 1'b0, 1'b1, 1'b1, KIND_CONTENT, 8'h00, 16'd0, 32'd2, 16'd1},
		'{data: CH_CR, default: '0},
		'{data: 8'h5A, eoi: 1'b1, default: '0},
		'{data: CH_QUOTE, default: '0},
		'{data: DELIMITER_RESET, default: '0},
		'{data: CH_QUOTE, default: '0},
		'{data: CH_QUOTE, default: '0},
		'{data: CH_CR, default: '0},
		'{data: CH_LF, default: '0},
		'{data: CH_QUOTE, default: '0},
		'{data: DELIMITER_RESET, default: '0},
		'{data: 8'hFF, eoi: 1'b1, default: '0},
		'{data: CH_QUOTE, default: '0},
		'{data: CH_QUOTE, default: '0},
		'{data: 8'h7A, default: '0},
		'{data: CH_QUOTE, default: '0},
		'{data: 8'h79, default: '0},
		'{data: CH_QUOTE, default: '0},
		'{data: 8'h01, eoi: 1'b1, default: '0}
	};

	function automatic void clear_parse();
		pstate = PS_ROW_START;
		cr_held = 1'b0;
		cols_now = '0;
		rows_now = '0;
		widest_now = '0;
	endfunction

	function automatic void emit_token(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] v);
		csvt_res_t r;
		r.kind = k;
		r.value = v;
		r.column_count = cols_now;
		r.row_number = rows_now;
		r.max_columns = widest_now;
		step_tokens.push_back(r);
	endfunction

	// a CR is held until the next byte shows whether it ends the field
	function automatic void field_byte(logic [BYTE_W-1:0] b);
		if (cr_held) begin
			emit_token(KIND_CONTENT, CH_CR);
			cr_held = 1'b0;
		end
		if (b == CH_CR)
			cr_held = 1'b1;
		else
			emit_token(KIND_CONTENT, b);
	endfunction

	function automatic void close_field(logic [BYTE_W-1:0] b, logic at_end);
		logic goes_on;
		goes_on = !at_end && b == delim_cfg;
		if (cr_held && (at_end || b != CH_LF))
			emit_token(KIND_CONTENT, CH_CR);
		cr_held = 1'b0;
		if (cols_now != '1)
			cols_now++;
		if (goes_on) begin
			emit_token(KIND_FIELD_END, '0);
			pstate = PS_FIELD_START;
		end else begin
			if (cols_now > widest_now)
				widest_now = cols_now;
			emit_token(KIND_ROW_END, '0);
			cols_now = '0;
			if (rows_now != '1)
				rows_now++;
			pstate = PS_ROW_START;
		end
	endfunction

	function automatic void tokenize(logic [BYTE_W-1:0] b, logic eoi, logic keep);
		token_t t;
		step_tokens.delete();
		if (eoi) begin
			case (pstate)
				PS_FIELD_START, PS_PLAIN, PS_QUOTE_SEEN: close_field(b, 1'b1);
				PS_QUOTED: emit_token(KIND_UNTERMINATED, '0);
				default: ;
			endcase
			clear_parse();
		end else begin
			case (pstate)
				PS_PLAIN: begin
					if (b == delim_cfg || b == CH_LF)
						close_field(b, 1'b0);
					else
						field_byte(b);
				end
				PS_QUOTED: begin
					if (b == CH_QUOTE)
						pstate = PS_QUOTE_SEEN;
					else
						field_byte(b);
				end
				PS_QUOTE_SEEN: begin
					if (b == CH_QUOTE) begin
						field_byte(CH_QUOTE);
						pstate = PS_QUOTED;
					end else begin
						close_field(b, 1'b0);
					end
				end
				default: begin
					cr_held = 1'b0;
					if (b == CH_QUOTE) begin
						pstate = PS_QUOTED;
					end else if (b == delim_cfg || b == CH_LF) begin
						close_field(b, 1'b0);
					end else begin
						pstate = PS_PLAIN;
						field_byte(b);
					end
				end
			endcase
		end
		if (keep) begin
			foreach (step_tokens[i]) begin
				t.res = step_tokens[i];
				t.last = (i == step_tokens.size() - 1);
				due_tokens.push_back(t);
			end
		end
	endfunction

	function automatic string show(token_t t);
		return $sformatf("kind=%0d value=%h cols=%0d row=%0d max=%0d last=%0b",
			t.res.kind, t.res.value, t.res.column_count, t.res.row_number,
			t.res.max_columns, t.last);
	endfunction

	function automatic void check_token(token_t got);
		token_t want;
		if (due_tokens.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("testbench: token with none expected: %s", show(got));
			return;
		end
		want = due_tokens.pop_front();
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display("testbench: mismatch\n  expected %s\n  actual   %s",
					show(want), show(got));
		end
	endfunction

	// mostly short gaps, a few long ones, now and then a calm stretch with none
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [BYTE_W-1:0] text_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 8'($urandom_range(97, 122));
		if (r == 6)
			return CH_CR;
		if (r == 7)
			return 8'($urandom_range(1, 255));
		if (r == 8)
			return delim_cfg;
		return CH_LF;
	endfunction

	// one row of fields, plain or quoted, closed by LF, CR LF or end of input
	function automatic void build_record();
		int fields;
		int len;
		logic [BYTE_W-1:0] c;
		fields = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 4);
		for (int f = 0; f < fields; f++) begin
			if (f > 0)
				doc_queue.push_back('{delim_cfg, 1'b0});
			len = $urandom_range(0, 5);
			if ($urandom_range(0, 4) < 2) begin
				doc_queue.push_back('{CH_QUOTE, 1'b0});
				for (int i = 0; i < len; i++) begin
					c = ($urandom_range(0, 7) == 0) ? CH_QUOTE : text_byte();
					if (c == CH_QUOTE)
						doc_queue.push_back('{CH_QUOTE, 1'b0});
					doc_queue.push_back('{c, 1'b0});
				end
				doc_queue.push_back('{CH_QUOTE, 1'b0});
			end else begin
				for (int i = 0; i < len; i++) begin
					c = text_byte();
					if (c == delim_cfg || c == CH_LF || (i == 0 && c == CH_QUOTE))
						c = 8'h78;
					doc_queue.push_back('{c, 1'b0});
				end
			end
		end
		case ($urandom_range(0, 19))
			0, 1: doc_queue.push_back('{8'($urandom_range(0, 255)), 1'b1});
			2, 3, 4, 5: begin
				doc_queue.push_back('{CH_CR, 1'b0});
				doc_queue.push_back('{CH_LF, 1'b0});
			end
			default: doc_queue.push_back('{CH_LF, 1'b0});
		endcase
	endfunction

	function automatic void build_noise();
		int cnt;
		cnt = $urandom_range(1, 6);
		repeat (cnt) begin
			case ($urandom_range(0, 11))
				0: doc_queue.push_back('{8'($urandom_range(0, 255)), 1'b1});
				1: doc_queue.push_back('{CH_QUOTE, 1'b0});
				2: doc_queue.push_back('{delim_cfg, 1'b0});
				3: doc_queue.push_back('{CH_LF, 1'b0});
				4: doc_queue.push_back('{CH_CR, 1'b0});
				default: doc_queue.push_back('{8'($urandom_range(1, 255)), 1'b0});
			endcase
		end
	endfunction

	// returns at the edge that completes the transfer
	task automatic offer(input doc_item_t it);
		int gap;
		gap = idle_len(send_calm);
		if (gap > 0) begin
			bytes_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bytes_if.valid <= 1'b1;
		bytes_if.data_byte <= it.data;
		bytes_if.end_of_input <= it.eoi;
		@(posedge clk);
		while (!bytes_if.ready)
			@(posedge clk);
	endtask

	// drop valid, wait for every token, then let bytes without tokens drain
	task automatic drain_block();
		bytes_if.valid <= 1'b0;
		while (due_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_delimiter(input logic [BYTE_W-1:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= DELIM_ADDR;
		pwdata <= APB_DATA_W'(d);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		delim_cfg = d;
	endtask

	initial begin : stimulus
		int sent;
		logic [BYTE_W-1:0] phase_delims [8];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		bytes_if.valid <= 1'b0;
		bytes_if.data_byte <= '0;
		bytes_if.end_of_input <= 1'b0;
		delim_cfg = DELIMITER_RESET;
		clear_parse();
		phase_delims = '{DELIMITER_RESET, 8'h09, 8'h01, 8'hFF, CH_QUOTE, CH_CR, CH_LF, 8'h00};
		phase_delims[7] = 8'($urandom_range(1, 255));
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_bytes[i]) begin
			offer('{opening_bytes[i].data, opening_bytes[i].eoi});
			tokenize(opening_bytes[i].data, opening_bytes[i].eoi, !opening_bytes[i].typed);
			if (opening_bytes[i].typed && opening_bytes[i].has_token)
				due_tokens.push_back('{'{opening_bytes[i].kind, opening_bytes[i].value,
					opening_bytes[i].cols, opening_bytes[i].row, opening_bytes[i].widest},
					1'b1});
		end

		for (int p = 0; p < 8; p++) begin
			if (p > 0) begin
				drain_block();
				write_delimiter(phase_delims[p]);
			end
			sent = 0;
			while (sent < PHASE_ITEMS || doc_queue.size() != 0) begin
				if (doc_queue.size() == 0) begin
					if ($urandom_range(0, 6) == 0)
						build_noise();
					else
						build_record();
				end
				offer(doc_queue[0]);
				tokenize(doc_queue[0].data, doc_queue[0].eoi, 1'b1);
				void'(doc_queue.pop_front());
				sent++;
			end
		end

		drain_block();
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin : sink
		int stall_left;
		int sink_calm;
		int taken;
		token_t got;
		stall_left = 0;
		sink_calm = 0;
		taken = 0;
		tokens_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (tokens_if.valid && tokens_if.ready) begin
				got = '{'{tokens_if.kind, tokens_if.value, tokens_if.column_count,
					tokens_if.row_number, tokens_if.max_columns}, tokens_if.last};
				check_token(got);
				taken++;
				// hold off long enough for the byte side to back up
				if (taken == 150 || taken == 600)
					stall_left = 300;
			end
			if (stall_left == 0)
				stall_left = idle_len(sink_calm);
			if (stall_left > 0) begin
				stall_left--;
				tokens_if.ready <= 1'b0;
			end else begin
				tokens_if.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#10ms;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
